// ----- rtl/qcd_pkg.sv -----
// Shared types and constants for the quad channel quadrature decoder.
// Holds the operation codes, the Gray-code step table and the stage structs.
// No dependencies.
`default_nettype none

package qcd_pkg;

	localparam int OP_W       = 2;
	localparam int CH_W       = 2;
	localparam int PHASE_W    = 2;
	localparam int STEP_W     = 2;
	localparam int POS_W      = 32;
	localparam int NUM_INVERT = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_RESET  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// Index is {old A/B pair, new A/B pair}; entries are signed steps.
	localparam logic [STEP_W-1:0] GRAY_STEP [16] = '{
		2'b00, 2'b01, 2'b11, 2'b00,
		2'b11, 2'b00, 2'b00, 2'b01,
		2'b01, 2'b00, 2'b00, 2'b11,
		2'b00, 2'b11, 2'b01, 2'b00
	};

	// Item context handed from the issue stage to the update logic.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [PHASE_W-1:0] phase;
		logic               impl;
		logic               inv;
	} ctx_t;

	// Update results that do not depend on the count width.
	typedef struct packed {
		logic                     wr_en;
		logic [PHASE_W-1:0]       new_phase;
		logic signed [STEP_W-1:0] step;
		logic signed [POS_W-1:0]  position;
	} upd_t;

endpackage

`default_nettype wire

// ----- rtl/qcd_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; used for the per-channel state store.
`default_nettype none

module qcd_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 4
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/qcd_update.sv -----
// Read-modify-write logic for one channel entry: Gray-code step lookup,
// count update and signed position output. Depends on qcd_pkg.
`default_nettype none

module qcd_update #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire qcd_pkg::ctx_t                ctx,
	input  wire  [COUNT_WIDTH-1:0]            cur_count,
	input  wire  [qcd_pkg::PHASE_W-1:0]       cur_phase,
	output logic [COUNT_WIDTH-1:0]            new_count,
	output qcd_pkg::upd_t                     upd
);

	logic [qcd_pkg::STEP_W-1:0]       tbl_step;
	logic [qcd_pkg::STEP_W-1:0]       step_raw;
	logic                             wr_en;
	logic signed [qcd_pkg::POS_W-1:0] pos_raw;

	assign tbl_step = qcd_pkg::GRAY_STEP[{cur_phase, ctx.phase}];

	always_comb begin
		step_raw  = '0;
		new_count = cur_count;
		wr_en     = 1'b0;
		case (ctx.op)
			qcd_pkg::OP_SAMPLE: begin
				step_raw  = tbl_step;
				new_count = cur_count
					+ {{(COUNT_WIDTH-qcd_pkg::STEP_W){tbl_step[1]}}, tbl_step};
				wr_en     = ctx.impl;
			end
			qcd_pkg::OP_RESET: begin
				new_count = '0;
				wr_en     = ctx.impl;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign pos_raw = qcd_pkg::POS_W'(signed'(new_count));

	always_comb begin
		upd.wr_en     = wr_en;
		upd.new_phase = ctx.phase;
		if (!ctx.impl) begin
			upd.step     = '0;
			upd.position = '0;
		end else begin
			upd.step     = step_raw;
			upd.position = ctx.inv ? -pos_raw : pos_raw;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/quad_channel_quadrature_decoder.sv -----
// Four-channel x4 quadrature decoder: streaming input and output channels,
// per-channel state held in a synchronous RAM. Depends on qcd_pkg,
// qcd_ram and qcd_update.
//
// Usage:
// Each input transaction on s_axis carries an operation, a channel index and
// that channel's current A/B phase pair. A sample adds the Gray-code step
// (+1, -1 or 0) to the channel count, a reset clears the count, a read only
// reports. Every input transaction yields exactly one output transaction on
// m_axis with the position (negated when that channel's invert register is
// set) and the step applied. Channels at or above CHANNELS report zero.
// Throughput is one transaction per cycle unless the receiver stalls: the
// state RAM is read at acceptance and written back as the item leaves the
// update stage, and a write to the channel read in the same cycle is
// forwarded, so consecutive items on one channel need no bubble. On a
// receiver stall the result waits in the output register, one more item
// enters the update stage and s_axis_tready drops until the output drains.
// Reset clears the invert registers, the pipeline valids and the
// per-channel valid bits, so every channel reads as count zero and phase
// pair zero until first written. The user writes the invert registers via
// cfg_we/cfg_index/cfg_data only while idle; the block never enforces it.
`default_nettype none

module quad_channel_quadrature_decoder #(
	parameter int CHANNELS    = 4,
	parameter int COUNT_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] operation, [3:2] channel, [5:4] phase_ab, [7:6] zero
	input  wire  [qcd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [31:0] position, [33:32] step, [39:34] zero
	output logic [qcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  wire                                 cfg_we,
	input  wire  [1:0]                          cfg_index,
	input  wire  [0:0]                          cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EW = COUNT_WIDTH + qcd_pkg::PHASE_W;

	// Input field split.
	logic [qcd_pkg::OP_W-1:0]    in_op;
	logic [qcd_pkg::CH_W-1:0]    in_ch;
	logic [qcd_pkg::PHASE_W-1:0] in_phase;
	logic [AW+1:0]               in_ch_ext;
	logic [AW-1:0]               in_addr;
	logic                        in_impl;
	logic                        s_acc;

	assign in_op     = s_axis_tdata[1:0];
	assign in_ch     = s_axis_tdata[3:2];
	assign in_phase  = s_axis_tdata[5:4];
	assign in_ch_ext = {{AW{1'b0}}, in_ch};
	assign in_addr   = in_ch_ext[AW-1:0];
	assign in_impl   = (32'(in_ch) < CHANNELS);
	assign s_acc     = s_axis_tvalid && s_axis_tready;

	// Invert registers.
	logic [qcd_pkg::NUM_INVERT-1:0] inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= '0;
		end else if (cfg_we) begin
			inv_q[cfg_index] <= cfg_data[0];
		end
	end

	// Update stage registers.
	logic                        vld_s1;
	logic [qcd_pkg::OP_W-1:0]    op_s1;
	logic [qcd_pkg::CH_W-1:0]    ch_s1;
	logic [qcd_pkg::PHASE_W-1:0] phase_s1;
	logic                        impl_s1;
	logic                        fwd_s1;
	logic [EW-1:0]               fwd_ent_s1;
	logic                        ok_s1;

	logic                        s1_adv;
	logic [AW+1:0]               s1_ch_ext;
	logic [AW-1:0]               s1_addr;

	// Write-back port and per-entry valid bits.
	logic                        ram_we;
	logic [EW-1:0]               ram_wdata;
	logic [EW-1:0]               ram_rdata;
	logic [(2**AW)-1:0]          ent_vld_q;

	// Update results.
	qcd_pkg::ctx_t               ctx;
	qcd_pkg::upd_t               upd;
	logic [EW-1:0]               cur_ent;
	logic [COUNT_WIDTH-1:0]      new_count;

	// Output register.
	logic                        m_vld_q;
	logic signed [qcd_pkg::POS_W-1:0]  pos_q;
	logic signed [qcd_pkg::STEP_W-1:0] step_q;

	assign s1_adv        = vld_s1 && (!m_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || s1_adv;
	assign s1_ch_ext     = {{AW{1'b0}}, ch_s1};
	assign s1_addr       = s1_ch_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// The RAM read issued at acceptance misses a write-back landing on the
	// same entry in that cycle, so that write is captured for forwarding.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1      <= in_op;
			ch_s1      <= in_ch;
			phase_s1   <= in_phase;
			impl_s1    <= in_impl;
			fwd_s1     <= ram_we && (s1_addr == in_addr);
			fwd_ent_s1 <= ram_wdata;
			ok_s1      <= ent_vld_q[in_addr];
		end
	end

	qcd_ram #(
		.WIDTH(EW),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s1_addr),
		.wdata (ram_wdata),
		.re    (s_acc && in_impl),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// An entry never written reads as count zero, phase pair zero.
	assign cur_ent = fwd_s1 ? fwd_ent_s1 : (ok_s1 ? ram_rdata : '0);

	assign ctx = '{op: op_s1, phase: phase_s1, impl: impl_s1, inv: inv_q[ch_s1]};

	qcd_update #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_update (
		.ctx       (ctx),
		.cur_count (cur_ent[COUNT_WIDTH-1:0]),
		.cur_phase (cur_ent[EW-1:COUNT_WIDTH]),
		.new_count (new_count),
		.upd       (upd)
	);

	assign ram_we    = s1_adv && upd.wr_en;
	assign ram_wdata = {upd.new_phase, new_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (ram_we) begin
			ent_vld_q[s1_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (s1_adv) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pos_q  <= upd.position;
			step_q <= upd.step;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {6'd0, step_q, pos_q};

	// Input back-pressure only arises with both stages full and a stalled sink.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && m_vld_q && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// A write-back to the entry being read must be forwarded to the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && ram_we && (s1_addr == in_addr)) |=> fwd_s1)
		else $error("same-entry write-back not forwarded");

	// A channel reset always stores a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (op_s1 == qcd_pkg::OP_RESET)) |-> (new_count == '0))
		else $error("channel reset wrote a nonzero count");

	// Only sample and reset operations on implemented channels write state.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (impl_s1
			&& (op_s1 == qcd_pkg::OP_SAMPLE || op_s1 == qcd_pkg::OP_RESET)))
		else $error("state written by a read or an absent channel");

endmodule

`default_nettype wire
